// ===== src/hmtri_pkg.sv =====
// Shared types, constants and helper functions for the heightmap pixel to triangles block.
// Depends on nothing; every other file in src uses it by scoped names.
package hmtri_pkg;

    localparam int HEIGHT_BITS = 16;
    localparam int FRAC_BITS   = 8;
    localparam int Z_BITS      = HEIGHT_BITS + FRAC_BITS;
    localparam int SUM_BITS    = HEIGHT_BITS + 2;
    localparam int WIDE_BITS   = SUM_BITS + FRAC_BITS;
    localparam int QUOT_BITS   = SUM_BITS - 1;
    localparam int POS_BITS    = 10;
    localparam int DIM_BITS    = 11;
    localparam int COORD_BITS  = 12;
    localparam int ADDR_BITS   = 4;
    localparam int DATA_BITS   = 32;
    localparam int NUM_CORNERS = 4;
    localparam int NUM_SLOTS   = 12;
    localparam int SLOT_BITS   = 4;

    // Division by three of the corner sum uses a scaled reciprocal.
    localparam int RECIP_SHIFT = SUM_BITS + 2;
    localparam int RECIP_BITS  = SUM_BITS + 1;
    localparam logic [RECIP_BITS-1:0] RECIP_MUL = RECIP_BITS'((1 << RECIP_SHIFT) / 3 + 1);
    localparam int THIRD_ONE   = (1 << FRAC_BITS) / 3;
    localparam int THIRD_TWO   = (2 << FRAC_BITS) / 3;

    localparam logic [DIM_BITS-1:0] DIM_RESET = DIM_BITS'(1024);

    typedef enum logic [1:0] {
        REG_MAP_COLUMNS = 2'd0,
        REG_MAP_ROWS    = 2'd1,
        REG_MAKE_BASE   = 2'd2
    } t_reg_index;

    typedef enum logic [1:0] {
        KIND_TOP    = 2'd0,
        KIND_WALL   = 2'd1,
        KIND_BOTTOM = 2'd2
    } t_kind;

    // Output order of the triangles of one pixel.
    typedef enum logic [SLOT_BITS-1:0] {
        SLOT_TOP0   = 4'd0,
        SLOT_TOP1   = 4'd1,
        SLOT_NORTH0 = 4'd2,
        SLOT_NORTH1 = 4'd3,
        SLOT_EAST0  = 4'd4,
        SLOT_EAST1  = 4'd5,
        SLOT_SOUTH0 = 4'd6,
        SLOT_SOUTH1 = 4'd7,
        SLOT_WEST0  = 4'd8,
        SLOT_WEST1  = 4'd9,
        SLOT_BOT0   = 4'd10,
        SLOT_BOT1   = 4'd11
    } t_slot;

    typedef struct packed {
        logic [HEIGHT_BITS-1:0] height_center;
        logic [HEIGHT_BITS-1:0] height_nw;
        logic [HEIGHT_BITS-1:0] height_n;
        logic [HEIGHT_BITS-1:0] height_ne;
        logic [HEIGHT_BITS-1:0] height_e;
        logic [HEIGHT_BITS-1:0] height_se;
        logic [HEIGHT_BITS-1:0] height_s;
        logic [HEIGHT_BITS-1:0] height_sw;
        logic [HEIGHT_BITS-1:0] height_w;
        logic [POS_BITS-1:0]    pixel_column;
        logic [POS_BITS-1:0]    pixel_row;
    } t_pixel;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] ax_doubled;
        logic [COORD_BITS-1:0]        ay_doubled;
        logic [Z_BITS-1:0]            az_fixed;
        logic signed [COORD_BITS-1:0] bx_doubled;
        logic [COORD_BITS-1:0]        by_doubled;
        logic [Z_BITS-1:0]            bz_fixed;
        logic signed [COORD_BITS-1:0] cx_doubled;
        logic [COORD_BITS-1:0]        cy_doubled;
        logic [Z_BITS-1:0]            cz_fixed;
        t_kind                        triangle_kind;
        logic                         last_of_pixel;
    } t_triangle;

    // Square outline and edge flags of one pixel, carried beside the lanes.
    typedef struct packed {
        logic [COORD_BITS-1:0] x_left;
        logic [COORD_BITS-1:0] x_right;
        logic [COORD_BITS-1:0] y_top;
        logic [COORD_BITS-1:0] y_bottom;
        logic                  at_n;
        logic                  at_e;
        logic                  at_s;
        logic                  at_w;
        logic                  base;
    } t_geom;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [Z_BITS-1:0]     z;
    } t_vertex;

    function automatic logic [WIDE_BITS-1:0] frac_third(input logic [1:0] rem);
        logic [WIDE_BITS-1:0] val;
        case (rem)
            2'd1:    val = WIDE_BITS'(THIRD_ONE);
            2'd2:    val = WIDE_BITS'(THIRD_TWO);
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

// ===== src/hmtri_corner_lane.sv =====
// One corner lane: averages the pixel with its valid neighbors at one corner.
// Depends on hmtri_pkg for widths and the divide-by-three constants.
module hmtri_corner_lane (
    input  logic                            i_clk,
    input  logic                            i_en_a,
    input  logic                            i_en_b,
    input  logic [hmtri_pkg::HEIGHT_BITS-1:0] i_height_center,
    input  logic [hmtri_pkg::HEIGHT_BITS-1:0] i_height_1,
    input  logic [hmtri_pkg::HEIGHT_BITS-1:0] i_height_2,
    input  logic [hmtri_pkg::HEIGHT_BITS-1:0] i_height_3,
    input  logic [2:0]                      i_inside,
    output logic [hmtri_pkg::Z_BITS-1:0]    o_z
);

    localparam int SB = hmtri_pkg::SUM_BITS;
    localparam int WB = hmtri_pkg::WIDE_BITS;
    localparam int QB = hmtri_pkg::QUOT_BITS;

    logic [SB-1:0] r_sum_a, n_sum_a;
    logic [1:0]    r_cnt_a, n_cnt_a;
    logic [SB-1:0] r_sum_b;
    logic [1:0]    r_cnt_b;
    logic [QB-1:0] r_quot_b, n_quot_b;
    logic [SB+hmtri_pkg::RECIP_BITS-1:0] product;
    logic [SB-1:0] three_q;
    logic [1:0]    rem;
    logic [WB-1:0] sum_wide;
    logic [WB-1:0] z_wide;

    // Stage A: sum of the center and the neighbors that lie inside the map.
    always_comb begin
        n_sum_a = SB'(i_height_center)
                + (i_inside[0] ? SB'(i_height_1) : '0)
                + (i_inside[1] ? SB'(i_height_2) : '0)
                + (i_inside[2] ? SB'(i_height_3) : '0);
        n_cnt_a = 2'({1'b0, i_inside[0]}) + 2'({1'b0, i_inside[1]})
                + 2'({1'b0, i_inside[2]});
    end

    // Stage B: quotient by three through the reciprocal multiply.
    assign product  = (SB + hmtri_pkg::RECIP_BITS)'(r_sum_a) * hmtri_pkg::RECIP_MUL;
    assign n_quot_b = product[hmtri_pkg::RECIP_SHIFT +: QB];

    always_ff @(posedge i_clk) begin
        if (i_en_a) begin
            r_sum_a <= n_sum_a;
            r_cnt_a <= n_cnt_a;
        end
        if (i_en_b) begin
            r_sum_b  <= r_sum_a;
            r_cnt_b  <= r_cnt_a;
            r_quot_b <= n_quot_b;
        end
    end

    // The mean: shifts for one, two or four terms, quotient plus remainder thirds for three.
    always_comb begin
        three_q  = (SB'(r_quot_b) << 1) + SB'(r_quot_b);
        rem      = 2'(r_sum_b - three_q);
        sum_wide = WB'(r_sum_b) << hmtri_pkg::FRAC_BITS;
        case (r_cnt_b)
            2'd0:    z_wide = sum_wide;
            2'd1:    z_wide = sum_wide >> 1;
            2'd2:    z_wide = (WB'(r_quot_b) << hmtri_pkg::FRAC_BITS)
                            + hmtri_pkg::frac_third(rem);
            default: z_wide = sum_wide >> 2;
        endcase
    end

    assign o_z = z_wide[hmtri_pkg::Z_BITS-1:0];

endmodule

// ===== src/hmtri_emitter.sv =====
// Merging stage: gathers the four corner heights and issues the pixel's triangles one a cycle.
// Depends on hmtri_pkg for the geometry, vertex, triangle and slot types.
module hmtri_emitter (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  hmtri_pkg::t_geom      i_geom,
    input  logic [hmtri_pkg::Z_BITS-1:0] i_z [hmtri_pkg::NUM_CORNERS],
    output logic                  o_ready,
    output logic                  o_valid,
    output hmtri_pkg::t_triangle  o_triangle
);

    localparam int NS = hmtri_pkg::NUM_SLOTS;

    logic [NS-1:0] r_mask, n_mask, rest, load_mask;
    hmtri_pkg::t_geom r_geom;
    logic [hmtri_pkg::Z_BITS-1:0] r_z [hmtri_pkg::NUM_CORNERS];
    logic [hmtri_pkg::SLOT_BITS-1:0] slot;
    hmtri_pkg::t_vertex c1, c2, c3, c4, c1g, c2g, c3g, c4g, va, vb, vc;
    hmtri_pkg::t_kind kind;
    hmtri_pkg::t_triangle n_tri;

    // Lowest pending slot goes out first.
    always_comb begin
        slot = '0;
        for (int i = NS - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                slot = hmtri_pkg::SLOT_BITS'(i);
            end
        end
    end

    assign rest    = r_mask & (r_mask - NS'(1));
    assign o_ready = (rest == '0);

    always_comb begin
        load_mask = '0;
        load_mask[hmtri_pkg::SLOT_TOP0]   = 1'b1;
        load_mask[hmtri_pkg::SLOT_TOP1]   = 1'b1;
        load_mask[hmtri_pkg::SLOT_NORTH0] = i_geom.base & i_geom.at_n;
        load_mask[hmtri_pkg::SLOT_NORTH1] = i_geom.base & i_geom.at_n;
        load_mask[hmtri_pkg::SLOT_EAST0]  = i_geom.base & i_geom.at_e;
        load_mask[hmtri_pkg::SLOT_EAST1]  = i_geom.base & i_geom.at_e;
        load_mask[hmtri_pkg::SLOT_SOUTH0] = i_geom.base & i_geom.at_s;
        load_mask[hmtri_pkg::SLOT_SOUTH1] = i_geom.base & i_geom.at_s;
        load_mask[hmtri_pkg::SLOT_WEST0]  = i_geom.base & i_geom.at_w;
        load_mask[hmtri_pkg::SLOT_WEST1]  = i_geom.base & i_geom.at_w;
        load_mask[hmtri_pkg::SLOT_BOT0]   = i_geom.base;
        load_mask[hmtri_pkg::SLOT_BOT1]   = i_geom.base;
        n_mask = i_load ? load_mask : rest;
    end

    // Corners: c1 top left, c2 top right, c3 bottom right, c4 bottom left; g marks ground level.
    always_comb begin
        c1 = '{x: r_geom.x_left,  y: r_geom.y_top,    z: r_z[0]};
        c2 = '{x: r_geom.x_right, y: r_geom.y_top,    z: r_z[1]};
        c3 = '{x: r_geom.x_right, y: r_geom.y_bottom, z: r_z[2]};
        c4 = '{x: r_geom.x_left,  y: r_geom.y_bottom, z: r_z[3]};
        c1g = c1; c1g.z = '0;
        c2g = c2; c2g.z = '0;
        c3g = c3; c3g.z = '0;
        c4g = c4; c4g.z = '0;
    end

    // A wall on edge (a, b) is the pair (a, b, b ground) and (b ground, a ground, a).
    always_comb begin
        kind = hmtri_pkg::KIND_WALL;
        unique case (slot)
            hmtri_pkg::SLOT_TOP0: begin
                va = c4; vb = c2; vc = c1; kind = hmtri_pkg::KIND_TOP;
            end
            hmtri_pkg::SLOT_TOP1: begin
                va = c4; vb = c3; vc = c2; kind = hmtri_pkg::KIND_TOP;
            end
            hmtri_pkg::SLOT_NORTH0: begin va = c1;  vb = c2;  vc = c2g; end
            hmtri_pkg::SLOT_NORTH1: begin va = c2g; vb = c1g; vc = c1;  end
            hmtri_pkg::SLOT_EAST0:  begin va = c2;  vb = c3;  vc = c3g; end
            hmtri_pkg::SLOT_EAST1:  begin va = c3g; vb = c2g; vc = c2;  end
            hmtri_pkg::SLOT_SOUTH0: begin va = c3;  vb = c4;  vc = c4g; end
            hmtri_pkg::SLOT_SOUTH1: begin va = c4g; vb = c3g; vc = c3;  end
            hmtri_pkg::SLOT_WEST0:  begin va = c4;  vb = c1;  vc = c1g; end
            hmtri_pkg::SLOT_WEST1:  begin va = c1g; vb = c4g; vc = c4;  end
            hmtri_pkg::SLOT_BOT0: begin
                va = c1g; vb = c3g; vc = c4g; kind = hmtri_pkg::KIND_BOTTOM;
            end
            hmtri_pkg::SLOT_BOT1: begin
                va = c1g; vb = c2g; vc = c3g; kind = hmtri_pkg::KIND_BOTTOM;
            end
            default: begin
                va = c1g; vb = c2g; vc = c3g; kind = hmtri_pkg::KIND_BOTTOM;
            end
        endcase
        n_tri.ax_doubled    = va.x;
        n_tri.ay_doubled    = va.y;
        n_tri.az_fixed      = va.z;
        n_tri.bx_doubled    = vb.x;
        n_tri.by_doubled    = vb.y;
        n_tri.bz_fixed      = vb.z;
        n_tri.cx_doubled    = vc.x;
        n_tri.cy_doubled    = vc.y;
        n_tri.cz_fixed      = vc.z;
        n_tri.triangle_kind = kind;
        n_tri.last_of_pixel = (rest == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask  <= '0;
            o_valid <= 1'b0;
        end else begin
            r_mask  <= n_mask;
            o_valid <= (r_mask != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        o_triangle <= n_tri;
        if (i_load) begin
            r_geom <= i_geom;
            r_z    <= i_z;
        end
    end

    a_pending_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mask != '0) |=> o_valid)
        else $error("pending triangle was not emitted");

    a_bottom_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_triangle.triangle_kind == hmtri_pkg::KIND_BOTTOM
         && !o_triangle.last_of_pixel)
        |=> (o_valid && o_triangle.triangle_kind == hmtri_pkg::KIND_BOTTOM
             && o_triangle.last_of_pixel))
        else $error("bottom triangles did not close the pixel");

    a_wall_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_triangle.triangle_kind == hmtri_pkg::KIND_WALL)
        |-> !o_triangle.last_of_pixel)
        else $error("wall triangle marked last");

    a_load_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_ready)
        else $error("pixel loaded while triangles still pending");

endmodule

// ===== src/heightmap_pixel_to_triangles_top.sv =====
// Top level of the heightmap pixel to triangles block: APB registers, four corner lanes, emitter.
// Depends on hmtri_pkg, hmtri_corner_lane and hmtri_emitter.
//
//  Channel   Ports                                  Moves on
//  pixel     start, busy, i_pixel                   start high and busy low at a clock edge
//  triangle  o_valid, o_triangle                    every cycle o_valid is high
//  config    psel, penable, pwrite, paddr, pwdata,  psel, penable, pwrite and pready high
//            prdata, pready
//
// A pixel passes through lane stages A and B, then its triangles leave one per cycle,
// two to twelve of them, so the emitter sets the pace at which new pixels are taken.
// Reset is synchronous and active low; it clears the pipeline valid flags and the emitter.
// The triangle receiver cannot stall; busy rises only while the lanes hold a pixel that the
// emitter cannot yet take.
module heightmap_pixel_to_triangles_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  hmtri_pkg::t_pixel                i_pixel,
    output logic                             o_valid,
    output hmtri_pkg::t_triangle             o_triangle,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [hmtri_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [hmtri_pkg::DATA_BITS-1:0]  pwdata,
    output logic [hmtri_pkg::DATA_BITS-1:0]  prdata,
    output logic                             pready
);

    localparam int CB = hmtri_pkg::COORD_BITS;
    localparam int DB = hmtri_pkg::DIM_BITS;

    // Config registers; user must write them by APB transactions only while idle; not enforced.
    logic [DB-1:0] r_map_columns;
    logic [DB-1:0] r_map_rows;
    logic          r_make_base;
    logic          cfg_write;

    // Pipeline control: stage A holds lane sums, stage B the quotients.
    logic r_valid_a, r_valid_b;
    logic ready_a, ready_b, accept, em_load, em_ready;

    hmtri_pkg::t_geom n_geom, r_geom_a, r_geom_b;
    logic [CB-1:0] x_twice, y_span;
    logic at_n, at_e, at_s, at_w;
    logic [hmtri_pkg::Z_BITS-1:0] lane_z [hmtri_pkg::NUM_CORNERS];

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_columns <= hmtri_pkg::DIM_RESET;
            r_map_rows    <= hmtri_pkg::DIM_RESET;
            r_make_base   <= 1'b1;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                hmtri_pkg::REG_MAP_COLUMNS: r_map_columns <= pwdata[DB-1:0];
                hmtri_pkg::REG_MAP_ROWS:    r_map_rows    <= pwdata[DB-1:0];
                hmtri_pkg::REG_MAKE_BASE:   r_make_base   <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Register reads come straight from the registers.
    always_comb begin
        unique case (paddr[3:2])
            hmtri_pkg::REG_MAP_COLUMNS: prdata = hmtri_pkg::DATA_BITS'(r_map_columns);
            hmtri_pkg::REG_MAP_ROWS:    prdata = hmtri_pkg::DATA_BITS'(r_map_rows);
            hmtri_pkg::REG_MAKE_BASE:   prdata = hmtri_pkg::DATA_BITS'(r_make_base);
            default:                    prdata = '0;
        endcase
    end

    // Each stage moves on when the stage after it is empty or moving on too.
    assign ready_b = !r_valid_b || em_ready;
    assign ready_a = !r_valid_a || ready_b;
    assign em_load = r_valid_b && em_ready;
    assign busy    = !ready_a;
    assign accept  = start && ready_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
        end else begin
            if (ready_a) begin
                r_valid_a <= accept;
            end
            if (ready_b) begin
                r_valid_b <= r_valid_a;
            end
        end
    end

    // Edge tests and the doubled outline of the pixel square; coordinates wrap at 12 bits.
    always_comb begin
        at_n    = (i_pixel.pixel_row == '0);
        at_w    = (i_pixel.pixel_column == '0);
        at_e    = ((DB'(i_pixel.pixel_column) + DB'(1)) == r_map_columns);
        at_s    = ((DB'(i_pixel.pixel_row) + DB'(1)) == r_map_rows);
        x_twice = CB'({i_pixel.pixel_column, 1'b0});
        y_span  = CB'({r_map_rows, 1'b0}) - CB'({i_pixel.pixel_row, 1'b0});
        n_geom.x_left   = x_twice - CB'(1);
        n_geom.x_right  = x_twice + CB'(1);
        n_geom.y_top    = y_span + CB'(1);
        n_geom.y_bottom = y_span - CB'(1);
        n_geom.at_n     = at_n;
        n_geom.at_e     = at_e;
        n_geom.at_s     = at_s;
        n_geom.at_w     = at_w;
        n_geom.base     = r_make_base;
    end

    always_ff @(posedge i_clk) begin
        if (ready_a) begin
            r_geom_a <= n_geom;
        end
        if (ready_b) begin
            r_geom_b <= r_geom_a;
        end
    end

    // Four lanes, one per corner of the pixel square, clockwise from the top left.
    hmtri_corner_lane u_lane_nw (
        .i_clk           (i_clk),
        .i_en_a          (ready_a),
        .i_en_b          (ready_b),
        .i_height_center (i_pixel.height_center),
        .i_height_1      (i_pixel.height_nw),
        .i_height_2      (i_pixel.height_n),
        .i_height_3      (i_pixel.height_w),
        .i_inside        ({!at_w, !at_n, !at_n && !at_w}),
        .o_z             (lane_z[0])
    );

    hmtri_corner_lane u_lane_ne (
        .i_clk           (i_clk),
        .i_en_a          (ready_a),
        .i_en_b          (ready_b),
        .i_height_center (i_pixel.height_center),
        .i_height_1      (i_pixel.height_n),
        .i_height_2      (i_pixel.height_ne),
        .i_height_3      (i_pixel.height_e),
        .i_inside        ({!at_e, !at_n && !at_e, !at_n}),
        .o_z             (lane_z[1])
    );

    hmtri_corner_lane u_lane_se (
        .i_clk           (i_clk),
        .i_en_a          (ready_a),
        .i_en_b          (ready_b),
        .i_height_center (i_pixel.height_center),
        .i_height_1      (i_pixel.height_e),
        .i_height_2      (i_pixel.height_se),
        .i_height_3      (i_pixel.height_s),
        .i_inside        ({!at_s, !at_e && !at_s, !at_e}),
        .o_z             (lane_z[2])
    );

    hmtri_corner_lane u_lane_sw (
        .i_clk           (i_clk),
        .i_en_a          (ready_a),
        .i_en_b          (ready_b),
        .i_height_center (i_pixel.height_center),
        .i_height_1      (i_pixel.height_w),
        .i_height_2      (i_pixel.height_s),
        .i_height_3      (i_pixel.height_sw),
        .i_inside        ({!at_s && !at_w, !at_s, !at_w}),
        .o_z             (lane_z[3])
    );

    // The emitter merges the lanes' corner heights into the pixel's triangle list.
    hmtri_emitter u_emitter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (em_load),
        .i_geom     (r_geom_b),
        .i_z        (lane_z),
        .o_ready    (em_ready),
        .o_valid    (o_valid),
        .o_triangle (o_triangle)
    );

endmodule
